### rtl/iee_pkg.sv
// package for the infix expression evaluator
// token, operator, error codes and sequencer states; no dependencies
package iee_pkg;
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_NUM = 2'd0, CMD_OP = 2'd1, CMD_OPEN = 2'd2, CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_REM = 3'd4, OP_LPAREN = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_DIVZERO = 3'd1, ERR_UNDER = 3'd2,
    ERR_OVER = 3'd3, ERR_PAREN = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_LOOKOP, ST_POP1, ST_POP2, ST_EXEC,
    ST_DIVIDE, ST_WRITE, ST_FINAL, ST_READTOP, ST_RESULT
  } state_t;

  // precedence: 1 for add/sub, 2 for mul/div/rem, 0 otherwise
  function automatic logic [1:0] prec(input logic [2:0] op);
    if (op == OP_ADD || op == OP_SUB) prec = 2'd1;
    else if (op <= OP_REM) prec = 2'd2;
    else prec = 2'd0;
  endfunction
endpackage

### rtl/infix_expression_evaluator_unit.sv
// Infix expression evaluator: top level with stacks, sequencer and shared ALU.
// Depends on iee_pkg.
//
// Tokens enter on the in_ channel (valid/ready); one result per expression
// leaves on the out_ channel when a token with in_last_token set is done.
// A number or open paren is pushed once it is dispatched; an operator or close
// paren is first held against the top operator. Each reduction pops an operator
// and two numbers and pushes the result; a divide or remainder goes through the
// bit-serial divider shared by all reductions. A closing paren, operator or last
// token may reduce several stacked operators in turn, so latency grows with their number.
// in_ready is high only in the idle state; one token is worked at a time.
// The result waits in an output register; while out_ready is low the
// sequencer holds in ST_RESULT and takes no new token.
// Reset (rst_n low, synchronous) empties both stacks and clears the error
// latch; the stack memories need no clearing pass.
// Errors: the first error is kept, later tokens are dropped until the last
// token, and the result then shows value 0 with the error code.
module infix_expression_evaluator_unit
  import iee_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_operator_code,
  input  logic [30:0]        in_number_value,
  input  logic               in_last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_error_code
);
  // memories
  logic [31:0] num_mem [STACK_DEPTH];
  logic [2:0]  op_mem  [STACK_DEPTH];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] ntop_r, ntop_nxt, otop_r, otop_nxt;
  logic [2:0] err_r, err_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [2:0] iop_r, iop_nxt;
  logic [30:0] inum_r, inum_nxt;
  logic last_r, last_nxt;
  logic [2:0] rop_r, rop_nxt;
  logic [31:0] rhs_r, rhs_nxt, res_r, res_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [2:0] oerr_r, oerr_nxt;

  // registered memory read ports
  logic [PTR_W-1:0] nrd_addr, ord_addr;
  logic [31:0] nrd_r;
  logic [2:0] ord_r;
  logic nwe, owe;
  logic [PTR_W-1:0] nwa, owa;
  logic [31:0] nwd;
  logic [2:0] owd;

  // divider
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [31:0] dq_r, dq_nxt, dd_r, dd_nxt;
  logic [32:0] drem_r, drem_nxt;
  logic dnq_r, dnq_nxt, dnr_r, dnr_nxt;
  logic [32:0] dtrial;

  always_ff @(posedge clk) begin
    if (nwe) num_mem[nwa] <= nwd;
    if (owe) op_mem[owa] <= owd;
    nrd_r <= num_mem[nrd_addr];
    ord_r <= op_mem[ord_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ntop_r   <= '0;
      otop_r   <= '0;
      err_r    <= ERR_NONE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ntop_r   <= ntop_nxt;
      otop_r   <= otop_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; iop_r <= iop_nxt; inum_r <= inum_nxt; last_r <= last_nxt;
    rop_r <= rop_nxt; rhs_r <= rhs_nxt; res_r <= res_nxt;
    oval_r <= oval_nxt; oerr_r <= oerr_nxt;
    dcnt_r <= dcnt_nxt; dq_r <= dq_nxt; dd_r <= dd_nxt; drem_r <= drem_nxt;
    dnq_r <= dnq_nxt; dnr_r <= dnr_nxt;
  end

  assign dtrial = {drem_r[31:0], dq_r[31]} - {1'b0, dd_r};

  // sequencer
  always_comb begin
    logic [CNT_W-1:0] t1;
    logic stop;
    t1 = otop_r - 1'b1;
    stop = 1'b0;
    state_nxt = state_r;
    ntop_nxt = ntop_r; otop_nxt = otop_r; err_nxt = err_r;
    cmd_nxt = cmd_r; iop_nxt = iop_r; inum_nxt = inum_r; last_nxt = last_r;
    rop_nxt = rop_r; rhs_nxt = rhs_r; res_nxt = res_r;
    ovalid_nxt = ovalid_r; oval_nxt = oval_r; oerr_nxt = oerr_r;
    dcnt_nxt = dcnt_r; dq_nxt = dq_r; dd_nxt = dd_r; drem_nxt = drem_r;
    dnq_nxt = dnq_r; dnr_nxt = dnr_r;
    nrd_addr = ntop_r[PTR_W-1:0] - 1'b1;
    ord_addr = t1[PTR_W-1:0];
    nwe = 1'b0; owe = 1'b0;
    nwa = ntop_r[PTR_W-1:0]; owa = otop_r[PTR_W-1:0];
    nwd = res_r; owd = iop_r;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd; iop_nxt = in_operator_code;
          inum_nxt = in_number_value; last_nxt = in_last_token;
          state_nxt = ST_DISPATCH;
        end
      end
      // top-of-operator read is ready here
      ST_DISPATCH: begin
        if (err_r != ERR_NONE) begin
          state_nxt = last_r ? ST_FINAL : ST_IDLE;
        end else begin
          unique case (cmd_t'(cmd_r))
            CMD_NUM: begin
              if (ntop_r >= CNT_W'(STACK_DEPTH)) err_nxt = ERR_OVER;
              else begin
                nwe = 1'b1; nwd = {1'b0, inum_r}; ntop_nxt = ntop_r + 1'b1;
              end
              state_nxt = last_r ? ST_FINAL : ST_IDLE;
            end
            CMD_OPEN: begin
              if (otop_r >= CNT_W'(STACK_DEPTH)) err_nxt = ERR_OVER;
              else begin
                owe = 1'b1; owd = OP_LPAREN; otop_nxt = otop_r + 1'b1;
              end
              state_nxt = last_r ? ST_FINAL : ST_IDLE;
            end
            CMD_OP: state_nxt = (iop_r <= OP_REM) ? ST_LOOKOP :
                                (last_r ? ST_FINAL : ST_IDLE);
            default: state_nxt = ST_LOOKOP;
          endcase
        end
      end
      // decide: reduce the top operator or finish the token
      ST_LOOKOP: begin
        if (err_r != ERR_NONE) begin
          state_nxt = last_r ? ST_FINAL : ST_IDLE;
        end else if (cmd_r == CMD_OP) begin
          if (otop_r != '0 && ord_r != OP_LPAREN && prec(ord_r) >= prec(iop_r)) begin
            stop = 1'b0;
            state_nxt = ST_POP1;
          end else begin
            if (otop_r >= CNT_W'(STACK_DEPTH)) err_nxt = ERR_OVER;
            else begin
              owe = 1'b1; owd = iop_r; otop_nxt = otop_r + 1'b1;
            end
            stop = 1'b1;
          end
        end else if (cmd_r == CMD_CLOSE) begin
          if (otop_r == '0) begin
            err_nxt = ERR_PAREN; stop = 1'b1;
          end else if (ord_r == OP_LPAREN) begin
            otop_nxt = t1; stop = 1'b1;
          end else state_nxt = ST_POP1;
        end else begin
          // drain at end of expression
          if (otop_r == '0) begin
            state_nxt = ST_READTOP;
          end else if (ord_r == OP_LPAREN) begin
            err_nxt = ERR_PAREN; state_nxt = ST_READTOP;
          end else state_nxt = ST_POP1;
        end
        if (stop) state_nxt = last_r ? ST_FINAL : ST_IDLE;
      end
      // pop operator; start reading rhs
      ST_POP1: begin
        rop_nxt = ord_r;
        otop_nxt = t1;
        if (ntop_r < CNT_W'(2)) begin
          err_nxt = ERR_UNDER;
          state_nxt = ST_LOOKOP;
        end else begin
          ntop_nxt = ntop_r - 1'b1;
          state_nxt = ST_POP2;
        end
      end
      ST_POP2: begin
        rhs_nxt = nrd_r;
        ntop_nxt = ntop_r - 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_WRITE;
        unique case (rop_r)
          OP_ADD: res_nxt = nrd_r + rhs_r;
          OP_SUB: res_nxt = nrd_r - rhs_r;
          OP_MUL: res_nxt = nrd_r * rhs_r;
          OP_DIV, OP_REM: begin
            if (rhs_r == '0) begin
              err_nxt = ERR_DIVZERO;
              state_nxt = ST_LOOKOP;
            end else begin
              dq_nxt = nrd_r[31] ? -nrd_r : nrd_r;
              dd_nxt = rhs_r[31] ? -rhs_r : rhs_r;
              drem_nxt = '0;
              dcnt_nxt = 6'd32;
              dnq_nxt = nrd_r[31] ^ rhs_r[31];
              dnr_nxt = nrd_r[31];
              state_nxt = ST_DIVIDE;
            end
          end
          default: res_nxt = '0;
        endcase
      end
      // restoring divide, one quotient bit a cycle
      ST_DIVIDE: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - 1'b1;
          if (!dtrial[32]) begin
            drem_nxt = dtrial;
            dq_nxt = {dq_r[30:0], 1'b1};
          end else begin
            drem_nxt = {drem_r[31:0], dq_r[31]};
            dq_nxt = {dq_r[30:0], 1'b0};
          end
        end else begin
          if (rop_r == OP_DIV) res_nxt = dnq_r ? -dq_r : dq_r;
          else res_nxt = dnr_r ? -drem_r[31:0] : drem_r[31:0];
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        nwe = 1'b1; nwd = res_r; ntop_nxt = ntop_r + 1'b1;
        state_nxt = ST_LOOKOP;
      end
      // end of expression: drain remaining operators
      ST_FINAL: begin
        cmd_nxt = CMD_NUM;
        if (err_r != ERR_NONE) state_nxt = ST_READTOP;
        else begin
          last_nxt = 1'b1;
          iop_nxt = OP_LPAREN;
          state_nxt = ST_LOOKOP;
        end
        // mark drain mode via cmd_r == CMD_NUM with last set
      end
      ST_READTOP: begin
        oerr_nxt = err_r;
        oval_nxt = '0;
        if (err_r == ERR_NONE) begin
          if (ntop_r == '0) oerr_nxt = ERR_UNDER;
          else oval_nxt = nrd_r;
        end
        ovalid_nxt = 1'b1;
        ntop_nxt = '0; otop_nxt = '0; err_nxt = ERR_NONE;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_value = oval_r;
  assign out_error_code = oerr_r;
endmodule

### rtl/iee_checker.sv
// port-level checks for the infix expression evaluator
// depends on iee_pkg; bound to infix_expression_evaluator_unit
module iee_checker
  import iee_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [2:0]  out_error_code
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");
  // no token taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready with pending result");
  // error results carry value zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_value == '0)
    else $error("nonzero value with error");
  // error codes stay in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= ERR_PAREN) else $error("bad error code");
endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

### test/infix_expression_evaluator_unit_checker.sv
`timescale 1ns / 1ps
// checker for the infix expression evaluator: watches both channels, predicts
// each expression result with its own two-stack evaluator; depends on iee_pkg
module infix_expression_evaluator_unit_checker
  import iee_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_operator_code,
  input  logic [30:0]        in_number_value,
  input  logic               in_last_token,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_value,
  input  logic [2:0]         out_error_code,
  output int                 fail_count,
  output int                 pending_results
);

  typedef struct packed {
    logic [31:0] value;
    err_t        err;
  } expr_result_t;

  logic [31:0] num_stk [STACK_DEPTH];
  logic [2:0]  opr_stk [STACK_DEPTH];
  int          num_cnt;
  int          opr_cnt;
  err_t        err_hold;
  expr_result_t result_q[$];

  initial fail_count = 0;
  initial pending_results = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int rank(input logic [2:0] op);
    if (op == OP_ADD || op == OP_SUB) return 1;
    if (op <= OP_REM) return 2;
    return 0;
  endfunction

  function automatic void flag(input err_t e);
    if (err_hold == ERR_NONE) err_hold = e;
  endfunction

  function automatic void push_number(input logic [31:0] v);
    if (num_cnt >= STACK_DEPTH) flag(ERR_OVER);
    else begin
      num_stk[num_cnt] = v;
      num_cnt++;
    end
  endfunction

  function automatic void push_operator(input logic [2:0] op);
    if (opr_cnt >= STACK_DEPTH) flag(ERR_OVER);
    else begin
      opr_stk[opr_cnt] = op;
      opr_cnt++;
    end
  endfunction

  // pop one operator and apply it to the top two numbers
  function automatic void apply_top();
    logic [2:0] op;
    logic signed [31:0] lhs, rhs;
    logic [31:0] r;
    if (opr_cnt == 0) return;
    opr_cnt--;
    op = opr_stk[opr_cnt];
    if (num_cnt < 2) begin
      flag(ERR_UNDER);
      return;
    end
    rhs = num_stk[num_cnt-1];
    lhs = num_stk[num_cnt-2];
    num_cnt -= 2;
    r = '0;
    case (op)
      OP_ADD: r = lhs + rhs;
      OP_SUB: r = lhs - rhs;
      OP_MUL: r = lhs * rhs;
      OP_DIV, OP_REM: begin
        if (rhs == 0) begin
          flag(ERR_DIVZERO);
          return;
        end
        // most negative over -1 wraps, remainder zero
        if (lhs == 32'sh8000_0000 && rhs == -1) r = (op == OP_DIV) ? lhs : '0;
        else r = (op == OP_DIV) ? lhs / rhs : lhs % rhs;
      end
      default: r = '0;
    endcase
    num_stk[num_cnt] = r;
    num_cnt++;
  endfunction

  // evaluate one accepted token; queue a result on the last token
  function automatic void take_token(input logic [1:0] cmd, input logic [2:0] op,
                                     input logic [30:0] num, input logic last);
    expr_result_t res;
    if (err_hold == ERR_NONE) begin
      case (cmd)
        CMD_NUM: push_number({1'b0, num});
        CMD_OP: if (op <= OP_REM) begin
          while (err_hold == ERR_NONE && opr_cnt != 0 && opr_stk[opr_cnt-1] != OP_LPAREN
                 && rank(opr_stk[opr_cnt-1]) >= rank(op))
            apply_top();
          if (err_hold == ERR_NONE) push_operator(op);
        end
        CMD_OPEN: push_operator(OP_LPAREN);
        default: begin
          while (err_hold == ERR_NONE && opr_cnt != 0 && opr_stk[opr_cnt-1] != OP_LPAREN)
            apply_top();
          if (err_hold == ERR_NONE) begin
            if (opr_cnt == 0) flag(ERR_PAREN);
            else opr_cnt--;
          end
        end
      endcase
    end
    if (!last) return;
    // drain at end of expression
    while (err_hold == ERR_NONE && opr_cnt != 0) begin
      if (opr_stk[opr_cnt-1] == OP_LPAREN) flag(ERR_PAREN);
      else apply_top();
    end
    res.value = '0;
    if (err_hold == ERR_NONE) begin
      if (num_cnt == 0) flag(ERR_UNDER);
      else res.value = num_stk[num_cnt-1];
    end
    if (err_hold != ERR_NONE) res.value = '0;
    res.err = err_hold;
    result_q.insert(result_q.size(), res);
    num_cnt = 0;
    opr_cnt = 0;
    err_hold = ERR_NONE;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    expr_result_t exp_res;
    if (!rst_n) begin
      num_cnt = 0;
      opr_cnt = 0;
      err_hold = ERR_NONE;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) report("result transaction with nothing expected");
        else begin
          exp_res = result_q.pop_front();
          if (out_value !== exp_res.value)
            report($sformatf("value got %0d want %0d", out_value,
                             $signed(exp_res.value)));
          if (out_error_code !== exp_res.err)
            report($sformatf("error code got %0d want %0d", out_error_code, exp_res.err));
        end
      end
      if (in_valid && in_ready)
        take_token(in_cmd, in_operator_code, in_number_value, in_last_token);
    end
    pending_results = result_q.size();
  end

endmodule

### test/infix_expression_evaluator_unit_test.sv
`timescale 1ns / 1ps
// top of the infix expression evaluator test: clock, reset, token stimulus
// and verdict; depends on iee_pkg, the unit and its checker
module infix_expression_evaluator_unit_test
  import iee_pkg::*;
;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_cmd;
  logic [2:0]         in_operator_code;
  logic [30:0]        in_number_value;
  logic               in_last_token;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic [2:0]         out_error_code;
  int                 fail_count;
  int                 pending_results;
  int                 cycle_count;
  bit                 quiet_sender;
  bit                 quiet_receiver;
  bit                 hold_receiver;
  int                 tokens_sent;

  localparam int CYCLE_LIMIT = 2_000_000;
  // operator codes with no meaning
  localparam logic [2:0] OP_SPARE = 3'd6;
  localparam logic [2:0] OP_NONE = 3'd7;

  infix_expression_evaluator_unit dut (.*);

  infix_expression_evaluator_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** infix_expression_evaluator_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, a long hold-off when asked
  always @(negedge clk) begin
    if (hold_receiver) out_ready <= 1'b0;
    else if (quiet_receiver) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 11);
  end

  // send one token, idling at random first
  task automatic send_token(input logic [1:0] cmd, input logic [2:0] op,
                            input logic [30:0] num, input logic last);
    while (!quiet_sender && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_operator_code <= op;
    in_number_value <= num;
    in_last_token <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    tokens_sent++;
  endtask

  task automatic send_num(input logic [30:0] n, input logic last = 1'b0);
    send_token(CMD_NUM, OP_ADD, n, last);
  endtask

  task automatic send_op(input logic [2:0] op, input logic last = 1'b0);
    send_token(CMD_OP, op, 31'($urandom), last);
  endtask

  function automatic logic [30:0] rand_number();
    case ($urandom_range(5))
      0: return 31'($urandom_range(3));
      1: return 31'h7fff_ffff - 31'($urandom_range(3));
      2: return 31'($urandom_range(20));
      3: return 31'($urandom_range(1000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_operator();
    return ($urandom_range(49) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
  endfunction

  // expression with random content and nesting, well-formed but for rare spare operator codes
  task automatic send_expression(input int terms);
    int depth;
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if (depth < 6 && $urandom_range(3) == 0) begin
        send_token(CMD_OPEN, OP_ADD, 31'($urandom), 1'b0);
        depth++;
      end
      send_num(rand_number());
      if (depth > 0 && $urandom_range(2) == 0) begin
        send_token(CMD_CLOSE, OP_ADD, 31'($urandom), 1'b0);
        depth--;
      end
      if (t != terms - 1) send_op(rand_operator());
    end
    while (depth > 1) begin
      send_token(CMD_CLOSE, OP_ADD, 31'($urandom), 1'b0);
      depth--;
    end
    if (depth == 1) send_token(CMD_CLOSE, OP_ADD, 31'($urandom), 1'b1);
    else send_token(CMD_OP, OP_NONE, 31'($urandom), 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NUM;
    in_operator_code = OP_ADD;
    in_number_value = '0;
    in_last_token = 1'b0;
    out_ready = 1'b0;
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    hold_receiver = 1'b0;
    tokens_sent = 0;
    cycle_count = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operator, each error case
    send_num(31'h7fff_ffff); send_op(OP_ADD); send_num(31'h7fff_ffff, 1'b1);
    send_num(0); send_op(OP_SUB); send_num(31'h7fff_ffff); send_op(OP_SUB);
    send_num(1); send_op(OP_DIV); send_token(CMD_OPEN, OP_ADD, 0, 1'b0);
    send_num(0); send_op(OP_SUB); send_num(1); send_token(CMD_CLOSE, OP_ADD, 0, 1'b1);
    send_num(7); send_op(OP_REM); send_num(0, 1'b1);
    send_num(6); send_op(OP_MUL); send_num(7); send_op(OP_REM); send_num(4, 1'b1);
    send_op(OP_ADD, 1'b1);
    send_token(CMD_CLOSE, OP_ADD, 0, 1'b1);
    send_token(CMD_OPEN, OP_ADD, 0, 1'b0); send_num(3, 1'b1);
    send_token(CMD_OP, OP_SPARE, 0, 1'b1);
    send_num(1); send_num(2, 1'b1);
    for (int i = 0; i < 33; i++) send_num(31'(i));
    send_num(5, 1'b1);
    for (int i = 0; i < 33; i++) send_token(CMD_OPEN, OP_ADD, 0, 1'b0);
    send_num(1, 1'b1);
    // deep nesting: 31 open parens, one short of the stack depth
    for (int i = 0; i < 31; i++) send_token(CMD_OPEN, OP_ADD, 0, 1'b0);
    send_num(9);
    for (int i = 0; i < 31; i++) send_token(CMD_CLOSE, OP_ADD, 0, i == 30);

    // receiver holds off while the sender keeps going
    fork
      begin
        hold_receiver = 1'b1;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_expression(2);
        in_valid <= 1'b0;
        @(negedge clk);
      end
    join
    @(negedge clk);

    // random: mostly well-formed expressions, some noise
    while (tokens_sent < 1640) begin
      quiet_sender = (tokens_sent > 900 && tokens_sent < 1050);
      quiet_receiver = quiet_sender;
      if ($urandom_range(4) != 0) send_expression($urandom_range(1, 8));
      else send_token(2'($urandom_range(3)), 3'($urandom), 31'($urandom),
                      $urandom_range(5) == 0);
    end
    send_token(CMD_OP, OP_NONE, 0, 1'b1);
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("** infix_expression_evaluator_unit: PASSED **");
    else $display("** infix_expression_evaluator_unit: FAILED **");
    $finish;
  end

endmodule

### infix_expression_evaluator_unit.f
rtl/iee_pkg.sv
rtl/infix_expression_evaluator_unit.sv
rtl/iee_checker.sv
test/infix_expression_evaluator_unit_checker.sv
test/infix_expression_evaluator_unit_test.sv
